// ----- hdl/bdsd_pkg.sv -----
package bdsd_pkg;

   localparam int BUTTON_COUNT    = 8;
   localparam int SEQUENCE_LENGTH = 10;
   localparam int BUTTON_BITS     = $clog2(BUTTON_COUNT);
   localparam int POSITION_BITS   = 4;
   localparam int TIME_BITS       = 32;
   localparam int DEBOUNCE_BITS   = 20;
   localparam int CODE_BITS       = 30;
   localparam int CSR_DATA_BITS   = 30;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CODE_LSB_BITS   = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEQUENCE_CODE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUTTON_ENABLE = 2'd2;

   localparam logic CMD_PIN_CHANGE = 1'b0;
   localparam logic CMD_READ       = 1'b1;

   localparam logic KIND_EVENT    = 1'b0;
   localparam logic KIND_SNAPSHOT = 1'b1;

   localparam logic [BUTTON_COUNT-1:0] ENABLE_RESET = '1;

   typedef logic [BUTTON_COUNT-1:0] mask_type;
   typedef logic [TIME_BITS-1:0]    time_type;

endpackage

// ----- hdl/button_debounce_sequence_detect.sv -----
// path: an accepted request is registered in stage 1, then in the output register
// throughput: one request per cycle while rsp_stall does not hold the output; the
// change-time memory is read at accept and written back from stage 1, with forwarding
// for back-to-back requests to the same button
// reset: synchronous active high; clears masks, matcher and valid bits, config to defaults
module button_debounce_sequence_detect (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [bdsd_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [bdsd_pkg::CSR_DATA_BITS-1:0]       csr_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_command,
   input  logic [2:0]                               req_button,
   input  logic                                     req_level,
   input  logic [31:0]                              req_timestamp,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_kind,
   output logic [2:0]                               rsp_event_button,
   output logic                                     rsp_event_pressed,
   output logic                                     rsp_sequence_done,
   output logic [7:0]                               rsp_pressed_mask,
   output logic [7:0]                               rsp_just_pressed_mask,
   output logic [7:0]                               rsp_just_released_mask
);

   // configuration
   logic [bdsd_pkg::DEBOUNCE_BITS-1:0] debounce_time_ff;
   logic [bdsd_pkg::CODE_BITS-1:0]     sequence_code_ff;
   bdsd_pkg::mask_type                 button_enable_ff;

   // change-time memory and its valid bits
   bdsd_pkg::time_type                 last_time_mem [bdsd_pkg::BUTTON_COUNT];
   bdsd_pkg::time_type                 last_rd_ff;
   bdsd_pkg::mask_type                 known_ff;

   // state registers
   bdsd_pkg::mask_type                 pressed_ff, pressed_in;
   bdsd_pkg::mask_type                 just_pressed_ff, just_pressed_in;
   bdsd_pkg::mask_type                 just_released_ff, just_released_in;
   logic [bdsd_pkg::POSITION_BITS-1:0] position_ff, position_in;

   // stage 1
   logic                               s1_valid_ff;
   logic                               s1_command_ff;
   logic [bdsd_pkg::BUTTON_BITS-1:0]   s1_button_ff;
   logic                               s1_level_ff;
   bdsd_pkg::time_type                 s1_time_ff;
   logic                               s1_known_ff;
   logic                               s1_fwd_ff;
   bdsd_pkg::time_type                 s1_fwd_time_ff;

   // output register
   logic                               rsp_valid_ff;
   logic                               rsp_kind_ff;
   logic [bdsd_pkg::BUTTON_BITS-1:0]   rsp_button_ff;
   logic                               rsp_pressed_ff;
   logic                               rsp_done_ff;
   bdsd_pkg::mask_type                 rsp_pressed_mask_ff;
   bdsd_pkg::mask_type                 rsp_just_pressed_ff;
   bdsd_pkg::mask_type                 rsp_just_released_ff;

   logic                               advance;
   logic                               req_take;
   bdsd_pkg::time_type                 prev_time;
   bdsd_pkg::time_type                 elapsed;
   logic                               take_event;
   logic                               has_rsp;
   logic                               write_time;
   logic                               is_press;
   logic                               done;
   bdsd_pkg::mask_type                 button_bit;
   logic [bdsd_pkg::POSITION_BITS-1:0] pos_cur;
   logic [bdsd_pkg::CODE_LSB_BITS-1:0] code_lsb;
   logic [bdsd_pkg::BUTTON_BITS-1:0]   seq_entry;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      prev_time  = s1_fwd_ff ? s1_fwd_time_ff : (s1_known_ff ? last_rd_ff : '0);
      elapsed    = s1_time_ff - prev_time;
      take_event = (s1_command_ff == bdsd_pkg::CMD_PIN_CHANGE)
                   && button_enable_ff[s1_button_ff]
                   && !(elapsed < bdsd_pkg::TIME_BITS'(debounce_time_ff));
      has_rsp    = (s1_command_ff == bdsd_pkg::CMD_READ) || take_event;
      write_time = s1_valid_ff && advance && take_event;
      is_press   = !s1_level_ff;
      button_bit = bdsd_pkg::mask_type'(1) << s1_button_ff;

      pos_cur  = (position_ff >= bdsd_pkg::POSITION_BITS'(bdsd_pkg::SEQUENCE_LENGTH))
                 ? '0 : position_ff;
      code_lsb = bdsd_pkg::CODE_LSB_BITS'(pos_cur) * bdsd_pkg::CODE_LSB_BITS'(3);
      seq_entry = sequence_code_ff[code_lsb +: bdsd_pkg::BUTTON_BITS];

      pressed_in       = pressed_ff;
      just_pressed_in  = just_pressed_ff;
      just_released_in = just_released_ff;
      position_in      = position_ff;
      done             = 1'b0;

      if (s1_valid_ff && advance) begin
         if (s1_command_ff == bdsd_pkg::CMD_READ) begin
            just_pressed_in  = '0;
            just_released_in = '0;
         end else if (take_event) begin
            if (is_press) begin
               pressed_in       = pressed_ff | button_bit;
               just_pressed_in  = just_pressed_ff | button_bit;
               just_released_in = just_released_ff & ~button_bit;
               if (seq_entry == s1_button_ff) begin
                  if (pos_cur == bdsd_pkg::POSITION_BITS'(bdsd_pkg::SEQUENCE_LENGTH - 1)) begin
                     position_in = '0;
                     done        = 1'b1;
                  end else begin
                     position_in = pos_cur + 1'b1;
                  end
               end else begin
                  position_in = '0;
               end
            end else begin
               pressed_in       = pressed_ff & ~button_bit;
               just_released_in = just_released_ff | button_bit;
               just_pressed_in  = just_pressed_ff & ~button_bit;
            end
         end
      end
   end

   // memory: read at accept, write back from stage 1
   always_ff @(posedge clock) begin
      if (req_take) begin
         last_rd_ff <= last_time_mem[req_button];
      end
      if (write_time) begin
         last_time_mem[s1_button_ff] <= s1_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= '0;
         sequence_code_ff <= '0;
         button_enable_ff <= bdsd_pkg::ENABLE_RESET;
         known_ff         <= '0;
         pressed_ff       <= '0;
         just_pressed_ff  <= '0;
         just_released_ff <= '0;
         position_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               bdsd_pkg::CSR_DEBOUNCE_TIME: begin
                  debounce_time_ff <= csr_data[bdsd_pkg::DEBOUNCE_BITS-1:0];
               end
               bdsd_pkg::CSR_SEQUENCE_CODE: begin
                  sequence_code_ff <= csr_data[bdsd_pkg::CODE_BITS-1:0];
               end
               bdsd_pkg::CSR_BUTTON_ENABLE: begin
                  button_enable_ff <= csr_data[bdsd_pkg::BUTTON_COUNT-1:0];
               end
               default: begin
               end
            endcase
         end
         if (write_time) begin
            known_ff <= known_ff | button_bit;
         end
         pressed_ff       <= pressed_in;
         just_pressed_ff  <= just_pressed_in;
         just_released_ff <= just_released_in;
         position_ff      <= position_in;
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff && has_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff  <= req_command;
         s1_button_ff   <= req_button;
         s1_level_ff    <= req_level;
         s1_time_ff     <= req_timestamp;
         s1_known_ff    <= known_ff[req_button];
         s1_fwd_ff      <= write_time && (s1_button_ff == req_button);
         s1_fwd_time_ff <= s1_time_ff;
      end
      if (s1_valid_ff && advance) begin
         if (s1_command_ff == bdsd_pkg::CMD_READ) begin
            rsp_kind_ff          <= bdsd_pkg::KIND_SNAPSHOT;
            rsp_button_ff        <= '0;
            rsp_pressed_ff       <= 1'b0;
            rsp_done_ff          <= 1'b0;
            rsp_pressed_mask_ff  <= pressed_ff;
            rsp_just_pressed_ff  <= just_pressed_ff;
            rsp_just_released_ff <= just_released_ff;
         end else begin
            rsp_kind_ff          <= bdsd_pkg::KIND_EVENT;
            rsp_button_ff        <= s1_button_ff;
            rsp_pressed_ff       <= is_press;
            rsp_done_ff          <= done;
            rsp_pressed_mask_ff  <= '0;
            rsp_just_pressed_ff  <= '0;
            rsp_just_released_ff <= '0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_kind               = rsp_kind_ff;
   assign rsp_event_button       = rsp_button_ff;
   assign rsp_event_pressed      = rsp_pressed_ff;
   assign rsp_sequence_done      = rsp_done_ff;
   assign rsp_pressed_mask       = rsp_pressed_mask_ff;
   assign rsp_just_pressed_mask  = rsp_just_pressed_ff;
   assign rsp_just_released_mask = rsp_just_released_ff;

endmodule

// ----- tb/sv/tb_button_debounce_sequence_detect.sv -----
module tb_button_debounce_sequence_detect;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {GAP_CLEAR, GAP_EDGE, GAP_BOUNCE, GAP_WILD} gap_kind_type;

   typedef struct {
      logic               command;
      logic [2:0]         button;
      logic               level;
      bdsd_pkg::time_type stamp;
   } button_request_type;

   typedef struct packed {
      logic               kind;
      logic [2:0]         button;
      logic               pressed;
      logic               done;
      bdsd_pkg::mask_type held;
      bdsd_pkg::mask_type rose;
      bdsd_pkg::mask_type fell;
   } button_result_type;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                csr_write = 1'b0;
   logic [bdsd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [bdsd_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_command = 1'b0;
   logic [2:0]                          req_button = '0;
   logic                                req_level = 1'b0;
   logic [31:0]                         req_timestamp = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_kind;
   logic [2:0]                          rsp_event_button;
   logic                                rsp_event_pressed;
   logic                                rsp_sequence_done;
   logic [7:0]                          rsp_pressed_mask;
   logic [7:0]                          rsp_just_pressed_mask;
   logic [7:0]                          rsp_just_released_mask;

   // predicted block state and registers
   logic [bdsd_pkg::DEBOUNCE_BITS-1:0] debounce_ticks = '0;
   logic [bdsd_pkg::CODE_BITS-1:0]     code_word = '0;
   bdsd_pkg::mask_type                 enabled = bdsd_pkg::ENABLE_RESET;
   bdsd_pkg::time_type                 change_time [bdsd_pkg::BUTTON_COUNT];
   bdsd_pkg::mask_type                 held_bits = '0;
   bdsd_pkg::mask_type                 rose_bits = '0;
   bdsd_pkg::mask_type                 fell_bits = '0;
   logic [bdsd_pkg::POSITION_BITS-1:0] match_pos = '0;

   button_request_type pin_requests [$];
   button_result_type  awaited_results [$];
   button_request_type in_flight;
   bdsd_pkg::time_type gen_last [bdsd_pkg::BUTTON_COUNT];

   bit calm = 1'b0;
   int counted = 0;
   int idle_cycles = 0;
   int mismatch_count = 0;
   int read_count = 0;
   int event_count = 0;
   int drop_count = 0;
   int unlock_count = 0;
   int setting_count = 0;

   button_debounce_sequence_detect DUT (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_button            (req_button),
      .req_level             (req_level),
      .req_timestamp         (req_timestamp),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_event_button      (rsp_event_button),
      .rsp_event_pressed     (rsp_event_pressed),
      .rsp_sequence_done     (rsp_sequence_done),
      .rsp_pressed_mask      (rsp_pressed_mask),
      .rsp_just_pressed_mask (rsp_just_pressed_mask),
      .rsp_just_released_mask(rsp_just_released_mask)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [2:0] code_entry(input int k);
      if (3 * k >= bdsd_pkg::CODE_BITS) return 3'd0;
      return 3'(code_word >> (3 * k));
   endfunction

   function automatic string describe(input button_result_type r);
      return $sformatf("kind=%0d button=%0d pressed=%0d done=%0d held=%02h rose=%02h fell=%02h",
                       r.kind, r.button, r.pressed, r.done, r.held, r.rose, r.fell);
   endfunction

   task automatic debounce_predict(input button_request_type rq);
      button_result_type                  r;
      bdsd_pkg::time_type                 elapsed;
      bdsd_pkg::mask_type                 bitm;
      logic [bdsd_pkg::POSITION_BITS-1:0] pos;
      r = '0;
      elapsed = rq.stamp - change_time[rq.button];
      if (rq.command == bdsd_pkg::CMD_READ) begin
         r.kind = bdsd_pkg::KIND_SNAPSHOT;
         r.held = held_bits;
         r.rose = rose_bits;
         r.fell = fell_bits;
         rose_bits = '0;
         fell_bits = '0;
         awaited_results.push_back(r);
         read_count++;
      end else if (int'(rq.button) >= bdsd_pkg::BUTTON_COUNT || !enabled[rq.button] ||
                   elapsed < bdsd_pkg::time_type'(debounce_ticks)) begin
         drop_count++;
      end else begin
         bitm = bdsd_pkg::mask_type'(1) << rq.button;
         r.kind = bdsd_pkg::KIND_EVENT;
         r.button = rq.button;
         r.pressed = (rq.level == 1'b0);
         if (r.pressed) begin
            held_bits |= bitm;
            rose_bits |= bitm;
            fell_bits &= ~bitm;
            pos = (match_pos >= bdsd_pkg::SEQUENCE_LENGTH) ? '0 : match_pos;
            if (code_entry(int'(pos)) == rq.button) begin
               pos++;
               if (pos >= bdsd_pkg::SEQUENCE_LENGTH) begin
                  pos = '0;
                  r.done = 1'b1;
                  unlock_count++;
               end
            end else begin
               pos = '0;
            end
            match_pos = pos;
         end else begin
            held_bits &= ~bitm;
            fell_bits |= bitm;
            rose_bits &= ~bitm;
         end
         change_time[rq.button] = rq.stamp;
         awaited_results.push_back(r);
         event_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) debounce_predict(in_flight);
         if (!req_valid || !req_stall) begin
            if (pin_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
               in_flight = pin_requests.pop_front();
               req_command   <= in_flight.command;
               req_button    <= in_flight.button;
               req_level     <= in_flight.level;
               req_timestamp <= in_flight.stamp;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      button_result_type got;
      button_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_kind, rsp_event_button, rsp_event_pressed, rsp_sequence_done,
                   rsp_pressed_mask, rsp_just_pressed_mask, rsp_just_released_mask};
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: %s", describe(got));
            end else begin
               want = awaited_results.pop_front();
               if (got.kind !== want.kind || got.button !== want.button ||
                   got.pressed !== want.pressed || got.done !== want.done ||
                   got.held !== want.held || got.rose !== want.rose ||
                   got.fell !== want.fell) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("mismatch expected: %s", describe(want));
                     $display("         actual:   %s", describe(got));
                  end
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 17);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_register(input logic [bdsd_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [bdsd_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      unique case (idx)
         bdsd_pkg::CSR_DEBOUNCE_TIME: debounce_ticks = value[bdsd_pkg::DEBOUNCE_BITS-1:0];
         bdsd_pkg::CSR_SEQUENCE_CODE: code_word = value[bdsd_pkg::CODE_BITS-1:0];
         bdsd_pkg::CSR_BUTTON_ENABLE: enabled = value[bdsd_pkg::BUTTON_COUNT-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [bdsd_pkg::DEBOUNCE_BITS-1:0] db,
                                input logic [bdsd_pkg::CODE_BITS-1:0] code,
                                input bdsd_pkg::mask_type en);
      write_register(bdsd_pkg::CSR_DEBOUNCE_TIME, bdsd_pkg::CSR_DATA_BITS'(db));
      write_register(bdsd_pkg::CSR_SEQUENCE_CODE, bdsd_pkg::CSR_DATA_BITS'(code));
      write_register(bdsd_pkg::CSR_BUTTON_ENABLE, bdsd_pkg::CSR_DATA_BITS'(en));
      setting_count++;
      @(negedge clock);
   endtask

   task automatic drain_block();
      while (pin_requests.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_directed(input logic cmd, input logic [2:0] btn, input logic lvl,
                                input bdsd_pkg::time_type ts);
      button_request_type rq;
      rq.command = cmd;
      rq.button  = btn;
      rq.level   = lvl;
      rq.stamp   = ts;
      pin_requests.push_back(rq);
   endtask

   task automatic push_read();
      push_directed(bdsd_pkg::CMD_READ, 3'($urandom), 1'($urandom), $urandom);
      counted++;
   endtask

   task automatic push_pin(input logic [2:0] btn, input logic lvl, input gap_kind_type gap);
      bdsd_pkg::time_type ts;
      bdsd_pkg::time_type span;
      unique case (gap)
         GAP_CLEAR:  ts = gen_last[btn] + debounce_ticks + $urandom_range(0, 7);
         GAP_EDGE:   ts = gen_last[btn] + debounce_ticks + $urandom_range(0, 2) - 1;
         GAP_BOUNCE: ts = gen_last[btn] +
                          ((debounce_ticks == 0) ? 0 : $urandom_range(0, debounce_ticks - 1));
         default:    ts = $urandom_range(0, 1) ? $urandom :
                          32'hFFFF_FFFF - $urandom_range(0, 2 * debounce_ticks + 4);
      endcase
      span = ts - gen_last[btn];
      if (enabled[btn]) begin
         counted++;
         if (span >= bdsd_pkg::time_type'(debounce_ticks)) gen_last[btn] = ts;
      end
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, btn, lvl, ts);
   endtask

   // mostly complete press sequences, with chatter, wrong presses and reads mixed in
   task automatic fill_random(input int target);
      int roll;
      int first;
      counted = 0;
      foreach (gen_last[b]) gen_last[b] = change_time[b];
      while (counted < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            first = ($urandom_range(0, 4) == 0)
                    ? $urandom_range(1, bdsd_pkg::SEQUENCE_LENGTH - 1) : 0;
            for (int k = first; k < bdsd_pkg::SEQUENCE_LENGTH; k++) begin
               if ($urandom_range(0, 9) == 0)
                  push_pin(code_entry(k), 1'($urandom), GAP_BOUNCE);
               if ($urandom_range(0, 19) == 0)
                  push_pin(3'($urandom), 1'b0, GAP_CLEAR);
               push_pin(code_entry(k), 1'b0, GAP_CLEAR);
               push_pin(code_entry(k), 1'b1, ($urandom_range(0, 4) == 0) ? GAP_EDGE : GAP_CLEAR);
               if ($urandom_range(0, 11) == 0) push_read();
            end
            push_read();
         end else if (roll < 85) begin
            repeat ($urandom_range(1, 12))
               push_pin(3'($urandom), 1'($urandom), gap_kind_type'($urandom_range(0, 3)));
         end else begin
            push_read();
         end
      end
   endtask

   task automatic run_phase(input logic [bdsd_pkg::DEBOUNCE_BITS-1:0] db,
                            input logic [bdsd_pkg::CODE_BITS-1:0] code,
                            input bdsd_pkg::mask_type en, input int target);
      apply_setting(db, code, en);
      fill_random(target);
      drain_block();
   endtask

   // codes built from two buttons so a wrong press often equals the first entry
   function automatic logic [bdsd_pkg::CODE_BITS-1:0] paired_code();
      logic [2:0]                     a;
      logic [2:0]                     b;
      logic [bdsd_pkg::CODE_BITS-1:0] code;
      a = 3'($urandom);
      b = 3'($urandom);
      code = '0;
      for (int k = 0; k < bdsd_pkg::SEQUENCE_LENGTH; k++)
         code |= bdsd_pkg::CODE_BITS'($urandom_range(0, 1) ? a : b) << (3 * k);
      return code;
   endfunction

   initial begin
      foreach (change_time[b]) change_time[b] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: no debounce, all-zero code
      push_directed(bdsd_pkg::CMD_READ, 3'd0, 1'b0, 32'h0);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd0, 1'b0, 32'h0);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd7, 1'b1, 32'hFFFF_FFFF);
      push_directed(bdsd_pkg::CMD_READ, 3'd7, 1'b1, 32'hFFFF_FFFF);
      drain_block();

      apply_setting(20'h100, 30'h0705_3977, 8'hFF);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd3, 1'b0, 32'h50);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd3, 1'b0, 32'hFF);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd3, 1'b0, 32'h100);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd3, 1'b0, 32'h150);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd3, 1'b1, 32'h200);
      push_directed(bdsd_pkg::CMD_READ, 3'd5, 1'b0, 32'h1234_5678);
      // timestamp wraps between these two
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd5, 1'b0, 32'hFFFF_FFF0);
      push_directed(bdsd_pkg::CMD_PIN_CHANGE, 3'd5, 1'b1, 32'h0000_00F0);
      for (int k = 0; k < bdsd_pkg::SEQUENCE_LENGTH; k++)
         push_directed(bdsd_pkg::CMD_PIN_CHANGE, code_entry(k), 1'b0,
                       bdsd_pkg::time_type'(32'h1000 * (k + 1)));
      push_directed(bdsd_pkg::CMD_READ, 3'd2, 1'b1, 32'h0);
      drain_block();

      run_phase(20'h0, bdsd_pkg::CODE_BITS'($urandom), 8'hFF, 265);
      run_phase(20'hFFFFF, 30'h3FFF_FFFF, 8'($urandom) | 8'h81, 265);
      calm = 1'b1;
      run_phase(20'($urandom_range(1, 64)), bdsd_pkg::CODE_BITS'($urandom), 8'hFF, 265);
      calm = 1'b0;
      run_phase(20'($urandom_range(1, 1000)), 30'h0, 8'h00, 10);
      run_phase(20'h1, paired_code(), 8'hFF, 265);
      run_phase(20'($urandom), bdsd_pkg::CODE_BITS'($urandom), 8'($urandom), 265);
      run_phase(20'($urandom_range(2, 16)), paired_code(), 8'hFF, 265);
      run_phase(20'h3, 30'h0, 8'hFF, 265);

      repeat (8) @(negedge clock);
      if (awaited_results.size() != 0) mismatch_count += awaited_results.size();
      $display("covered %0d requests under %0d register settings:",
               read_count + event_count + drop_count, setting_count);
      $display("%0d reads, %0d events, %0d dropped, %0d completed press sequences",
               read_count, event_count, drop_count, unlock_count);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
